// File: rtl/core/irc_line_tokenizer_top_macros.svh
// assertion macros used by the tokenizer checker
`ifndef IRC_LINE_TOKENIZER_TOP_MACROS_SVH
`define IRC_LINE_TOKENIZER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i and quiet during reset
`define IRC_TOK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("irc tokenizer check failed");

// next-cycle implication
`define IRC_TOK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("irc tokenizer check failed");

`endif

// File: rtl/core/irc_tok_pkg.sv
// types and constants of the chat line tokenizer
`default_nettype none
package irc_tok_pkg;

  localparam int unsigned MAX_PARAMS = 15;
  localparam int unsigned PREFIX_MAX = 63;

  localparam int BYTE_W  = 8;
  localparam int ROLE_W  = 3;
  localparam int SLOT_W  = 4;
  localparam int TOTAL_W = 5;
  localparam int PLEN_W  = 7;
  localparam int PSLOT_W = 5;

  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [ROLE_W-1:0] {
    ROLE_SEP     = 3'd0,
    ROLE_PREFIX  = 3'd1,
    ROLE_COMMAND = 3'd2,
    ROLE_MIDDLE  = 3'd3,
    ROLE_TRAIL   = 3'd4,
    ROLE_DROPPED = 3'd5
  } role_e;

  typedef enum logic [6:0] {
    PH_LEAD    = 7'b0000001,
    PH_PREFIX  = 7'b0000010,
    PH_POSTPFX = 7'b0000100,
    PH_COMMAND = 7'b0001000,
    PH_GAP     = 7'b0010000,
    PH_MIDDLE  = 7'b0100000,
    PH_TRAIL   = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_line;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  char_out;
    logic [ROLE_W-1:0]  role;
    logic [SLOT_W-1:0]  slot;
    logic               line_done;
    logic               empty_error;
    logic [TOTAL_W-1:0] slot_total;
  } result_t;

  // handshake between the stage registers
  typedef struct packed {
    logic valid;
    logic take;
  } stage_ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/irc_tok_if.sv
// valid/ready channel interfaces for input bytes and tagged results
`default_nettype none
interface irc_tok_in_if;
  logic                          valid;
  logic                          ready;
  logic [irc_tok_pkg::BYTE_W-1:0] data_byte;
  logic                          end_of_line;

  modport source (output valid, output data_byte, output end_of_line, input ready);
  modport sink (input valid, input data_byte, input end_of_line, output ready);
endinterface

interface irc_tok_out_if;
  logic                           valid;
  logic                           ready;
  logic [irc_tok_pkg::BYTE_W-1:0]  char_out;
  logic [irc_tok_pkg::ROLE_W-1:0]  role;
  logic [irc_tok_pkg::SLOT_W-1:0]  slot;
  logic                           line_done;
  logic                           empty_error;
  logic [irc_tok_pkg::TOTAL_W-1:0] slot_total;

  modport source (output valid, output char_out, output role, output slot,
                  output line_done, output empty_error, output slot_total, input ready);
  modport sink (input valid, input char_out, input role, input slot,
                input line_done, input empty_error, input slot_total, output ready);
endinterface
`default_nettype wire

// File: rtl/core/irc_tok_inreg.sv
// input register stage holding one byte of the line
`default_nettype none
module irc_tok_inreg (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  irc_tok_in_if.sink           in_i,
  input  wire logic            take_i,
  output irc_tok_pkg::item_t   item_o,
  output logic                 valid_o
);
  import irc_tok_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  assign in_i.ready = !valid_q || take_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.data_byte   <= in_i.data_byte;
      item_q.end_of_line <= in_i.end_of_line;
    end
  end

  assign item_o  = item_q;
  assign valid_o = valid_q;
endmodule
`default_nettype wire

// File: rtl/core/irc_tok_fsm.sv
// line parser state and per-byte role and slot tagging
`default_nettype none
module irc_tok_fsm (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire irc_tok_pkg::stage_ctl_t ctl_i,
  input  wire irc_tok_pkg::item_t      item_i,
  output irc_tok_pkg::result_t         res_o
);
  import irc_tok_pkg::*;

  phase_e             phase_q, phase_d;
  logic [PLEN_W-1:0]  plen_q, plen_d;
  logic [PSLOT_W-1:0] pslot_q, pslot_d;
  role_e              role;
  logic [PSLOT_W-1:0] slot_raw;
  logic               sp, colon, empty, fire;

  assign sp    = (item_i.data_byte == CH_SPACE);
  assign colon = (item_i.data_byte == CH_COLON);
  assign fire  = ctl_i.valid && ctl_i.take;

  always_comb begin
    phase_d  = phase_q;
    plen_d   = plen_q;
    pslot_d  = pslot_q;
    role     = ROLE_SEP;
    slot_raw = '0;
    case (phase_q)
      PH_LEAD: begin
        if (sp) begin
          role = ROLE_SEP;
        end else if (colon) begin
          phase_d = PH_PREFIX;
        end else begin
          phase_d = PH_COMMAND;
          role    = ROLE_COMMAND;
        end
      end
      PH_PREFIX: begin
        if (sp) begin
          phase_d = PH_POSTPFX;
        end else if (plen_q < PLEN_W'(PREFIX_MAX)) begin
          plen_d = plen_q + 1'b1;
          role   = ROLE_PREFIX;
        end else begin
          role = ROLE_DROPPED;
        end
      end
      PH_POSTPFX: begin
        if (!sp) begin
          phase_d = PH_COMMAND;
          role    = ROLE_COMMAND;
        end
      end
      PH_COMMAND: begin
        if (sp) begin
          phase_d = PH_GAP;
        end else begin
          role = ROLE_COMMAND;
        end
      end
      PH_GAP: begin
        if (!sp) begin
          pslot_d = pslot_q + 1'b1;
          // the colon marker opens its slot but carries no slot tag
          if (colon) begin
            phase_d = PH_TRAIL;
          end else begin
            phase_d  = PH_MIDDLE;
            role     = ROLE_MIDDLE;
            slot_raw = pslot_d;
          end
        end
      end
      PH_MIDDLE: begin
        // last slot swallows spaces up to line end
        if (sp && (pslot_q < PSLOT_W'(MAX_PARAMS))) begin
          phase_d = PH_GAP;
        end else begin
          role     = ROLE_MIDDLE;
          slot_raw = pslot_q;
        end
      end
      PH_TRAIL: begin
        role     = ROLE_TRAIL;
        slot_raw = pslot_q;
      end
      default: begin
        role = ROLE_SEP;
      end
    endcase
  end

  assign empty = (phase_d == PH_LEAD) || (phase_d == PH_PREFIX) || (phase_d == PH_POSTPFX);

  always_comb begin
    res_o.char_out    = item_i.data_byte;
    res_o.role        = role;
    res_o.slot        = slot_raw[SLOT_W-1:0];
    res_o.line_done   = item_i.end_of_line;
    res_o.empty_error = item_i.end_of_line && empty;
    res_o.slot_total  = '0;
    if (item_i.end_of_line) begin
      res_o.slot_total = empty ? TOTAL_W'(1) : TOTAL_W'(pslot_d + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      plen_q  <= '0;
      pslot_q <= '0;
    end else if (fire) begin
      if (item_i.end_of_line) begin
        phase_q <= PH_LEAD;
        plen_q  <= '0;
        pslot_q <= '0;
      end else begin
        phase_q <= phase_d;
        plen_q  <= plen_d;
        pslot_q <= pslot_d;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/irc_tok_outreg.sv
// result register driving the output channel
`default_nettype none
module irc_tok_outreg (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire irc_tok_pkg::result_t res_i,
  output logic                      take_o,
  irc_tok_out_if.source             out_o
);
  import irc_tok_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;
  logic    load;

  assign take_o = !valid_q || out_o.ready;
  assign load   = valid_i && take_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.char_out    = res_q.char_out;
  assign out_o.role        = res_q.role;
  assign out_o.slot        = res_q.slot;
  assign out_o.line_done   = res_q.line_done;
  assign out_o.empty_error = res_q.empty_error;
  assign out_o.slot_total  = res_q.slot_total;
endmodule
`default_nettype wire

// File: rtl/core/irc_line_tokenizer_top.sv
// Chat line tokenizer, top level.
// in_i carries one byte of a message line per word, with end_of_line on the
// final byte. out_o returns one word per input byte: the byte itself, its role
// (separator, prefix, command, middle or trailing parameter, dropped prefix)
// and its parameter slot. The word for the final byte also has line_done set,
// empty_error when no command was seen, and slot_total (filled slots plus one).
// An accepted byte is held in the input register, tagged by the parser and
// loaded into the result register, which drives out_o.
// Throughput: one byte per cycle while out_o.ready stays high, set by the
// single parser stage between the input register and the result register.
// Reset clears both stage valids and returns the parser to the start of a
// line. When the receiver holds ready low the result register keeps its
// word; the input register still takes one more byte, then in_i.ready drops
// until the result is taken.
`default_nettype none
module irc_line_tokenizer_top (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  irc_tok_in_if.sink     in_i,
  irc_tok_out_if.source  out_o
);
  import irc_tok_pkg::*;

  item_t      item;
  result_t    res;
  logic       s1_valid;
  logic       take;
  stage_ctl_t ctl;

  assign ctl.valid = s1_valid;
  assign ctl.take  = take;

  irc_tok_inreg u_inreg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .item_o  (item),
    .valid_o (s1_valid)
  );

  irc_tok_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .item_i (item),
    .res_o  (res)
  );

  irc_tok_outreg u_outreg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .res_i   (res),
    .take_o  (take),
    .out_o   (out_o)
  );
endmodule
`default_nettype wire

// File: rtl/core/irc_tok_checker.sv
// port-level checks for the chat line tokenizer and their binding
`default_nettype none
`include "irc_line_tokenizer_top_macros.svh"
module irc_tok_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           out_valid_i,
  input wire logic                           out_ready_i,
  input wire logic [irc_tok_pkg::ROLE_W-1:0]  role_i,
  input wire logic [irc_tok_pkg::SLOT_W-1:0]  slot_i,
  input wire logic                           line_done_i,
  input wire logic                           empty_error_i,
  input wire logic [irc_tok_pkg::TOTAL_W-1:0] slot_total_i
);
  import irc_tok_pkg::*;

  logic untagged_role;

  assign untagged_role = (role_i == ROLE_SEP) || (role_i == ROLE_PREFIX) ||
                         (role_i == ROLE_COMMAND) || (role_i == ROLE_DROPPED);

  // a stalled word stays on the channel
  `IRC_TOK_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  // line summary only on the final byte
  `IRC_TOK_ASSERT_NOW(a_total_at_end, out_valid_i && !line_done_i, slot_total_i == '0 && !empty_error_i)
  // an empty line has no parameter slots
  `IRC_TOK_ASSERT_NOW(a_empty_total, out_valid_i && empty_error_i, slot_total_i == TOTAL_W'(1))
  // prefix, command and separator bytes carry no slot
  `IRC_TOK_ASSERT_NOW(a_slot_zero, out_valid_i && untagged_role, slot_i == '0)
endmodule

bind irc_line_tokenizer_top irc_tok_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .role_i        (out_o.role),
  .slot_i        (out_o.slot),
  .line_done_i   (out_o.line_done),
  .empty_error_i (out_o.empty_error),
  .slot_total_i  (out_o.slot_total)
);
`default_nettype wire
